/* rtl/core/addressing_mode_effective_address_macros.svh */
// ----------------------------------------------------------------------------
// addressing mode effective address: assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ADDRESSING_MODE_EFFECTIVE_ADDRESS_MACROS_SVH
`define ADDRESSING_MODE_EFFECTIVE_ADDRESS_MACROS_SVH

`ifndef SYNTHESIS
// checked property, masked while reset is high
`define AME_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked property, never masked
`define AME_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AME_ASSERT(lbl, clk, rst, prop, msg)
`define AME_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* rtl/core/ame_pkg.sv */
// ----------------------------------------------------------------------------
// ame_pkg
// shared types and codes of the effective address sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package ame_pkg;

   // request opcodes
   localparam logic OP_START = 1'b0;
   localparam logic OP_DATA  = 1'b1;

   // result kinds
   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   // addressing modes
   localparam logic [3:0] MODE_ABS = 4'd0;
   localparam logic [3:0] MODE_IAX = 4'd1;
   localparam logic [3:0] MODE_AX  = 4'd2;
   localparam logic [3:0] MODE_AY  = 4'd3;
   localparam logic [3:0] MODE_IND = 4'd4;
   localparam logic [3:0] MODE_ACC = 4'd5;
   localparam logic [3:0] MODE_IMM = 4'd6;
   localparam logic [3:0] MODE_IMP = 4'd7;
   localparam logic [3:0] MODE_REL = 4'd8;
   localparam logic [3:0] MODE_ZP  = 4'd9;
   localparam logic [3:0] MODE_IZX = 4'd10;
   localparam logic [3:0] MODE_ZPX = 4'd11;
   localparam logic [3:0] MODE_ZPY = 4'd12;
   localparam logic [3:0] MODE_IZP = 4'd13;
   localparam logic [3:0] MODE_IZY = 4'd14;
   localparam logic [3:0] MODE_ZPR = 4'd15;

   // operand step counter
   localparam logic [1:0] STEP_0 = 2'd0;
   localparam logic [1:0] STEP_1 = 2'd1;
   localparam logic [1:0] STEP_2 = 2'd2;
   localparam logic [1:0] STEP_3 = 2'd3;

   typedef struct packed {
      logic        kind;
      logic [15:0] read_address;
      logic [15:0] effective_address;
      logic [15:0] next_pc;
      logic [15:0] relative_offset;
      logic        page_crossed;
   } result_type;

   typedef struct packed {
      logic       push;
      result_type data;
   } push_type;

endpackage

`default_nettype wire

/* rtl/core/ame_seq.sv */
// ----------------------------------------------------------------------------
// ame_seq
// addressing mode sequencer: state registers and per-transfer step logic
// ----------------------------------------------------------------------------
`default_nettype none

module ame_seq (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic             op,
   input  wire logic [3:0]       mode,
   input  wire logic [15:0]      pc,
   input  wire logic [7:0]       x,
   input  wire logic [7:0]       y,
   input  wire logic [7:0]       read_data,
   output ame_pkg::push_type     result
);

   typedef struct packed {
      logic        busy;
      logic [3:0]  mode;
      logic [1:0]  step;
      logic [15:0] pc;
      logic [7:0]  x;
      logic [7:0]  y;
      logic [15:0] ptr;
      logic [7:0]  low;
   } state_type;

   state_type state_ff;
   state_type state_in;

   ame_pkg::result_type res;
   logic                has_res;
   logic [15:0]         base;
   logic [15:0]         ea;
   logic [15:0]         index16;
   logic [15:0]         rel16;
   logic [7:0]          zp_ptr;

   function automatic ame_pkg::result_type make_read(input logic [15:0] addr);
      ame_pkg::result_type r;
      r                   = '0;
      r.kind              = ame_pkg::KIND_READ;
      r.read_address      = addr;
      return r;
   endfunction

   function automatic ame_pkg::result_type make_done(
      input logic [15:0] eff,
      input logic [15:0] npc,
      input logic [15:0] rel,
      input logic        crossed
   );
      ame_pkg::result_type r;
      r                   = '0;
      r.kind              = ame_pkg::KIND_DONE;
      r.effective_address = eff;
      r.next_pc           = npc;
      r.relative_offset   = rel;
      r.page_crossed      = crossed;
      return r;
   endfunction

   always_comb begin
      base    = {read_data, state_ff.low};
      rel16   = {{8{read_data[7]}}, read_data};
      index16 = 16'h0000;
      case (state_ff.mode)
         ame_pkg::MODE_AX, ame_pkg::MODE_IAX: index16 = {8'h00, state_ff.x};
         ame_pkg::MODE_AY, ame_pkg::MODE_IZY: index16 = {8'h00, state_ff.y};
         default:                             index16 = 16'h0000;
      endcase
      ea     = base + index16;
      zp_ptr = (state_ff.mode == ame_pkg::MODE_IZX) ? (read_data + state_ff.x) : read_data;
   end

   always_comb begin
      state_in = state_ff;
      has_res  = 1'b0;
      res      = '0;
      if (op == ame_pkg::OP_START) begin
         state_in.mode = mode;
         state_in.pc   = pc;
         state_in.x    = x;
         state_in.y    = y;
         state_in.step = ame_pkg::STEP_0;
         state_in.ptr  = 16'h0000;
         state_in.low  = 8'h00;
         state_in.busy = 1'b0;
         has_res       = 1'b1;
         case (mode)
            ame_pkg::MODE_ACC, ame_pkg::MODE_IMP: res = make_done(16'h0000, pc, 16'h0000, 1'b0);
            ame_pkg::MODE_IMM: res = make_done(pc, pc + 16'd1, 16'h0000, 1'b0);
            default: begin
               state_in.busy = 1'b1;
               res           = make_read(pc);
            end
         endcase
      end else if (state_ff.busy) begin
         has_res = 1'b1;
         case (state_ff.mode)
            ame_pkg::MODE_ABS, ame_pkg::MODE_AX, ame_pkg::MODE_AY: begin
               if (state_ff.step == ame_pkg::STEP_0) begin
                  state_in.low  = read_data;
                  state_in.step = ame_pkg::STEP_1;
                  res           = make_read(state_ff.pc + 16'd1);
               end else begin
                  state_in.busy = 1'b0;
                  res = make_done(ea, state_ff.pc + 16'd2, 16'h0000, base[15:8] != ea[15:8]);
               end
            end
            ame_pkg::MODE_IAX, ame_pkg::MODE_IND: begin
               case (state_ff.step)
                  ame_pkg::STEP_0: begin
                     state_in.low  = read_data;
                     state_in.step = ame_pkg::STEP_1;
                     res           = make_read(state_ff.pc + 16'd1);
                  end
                  ame_pkg::STEP_1: begin
                     state_in.ptr  = ea;
                     state_in.step = ame_pkg::STEP_2;
                     res           = make_read(ea);
                  end
                  ame_pkg::STEP_2: begin
                     state_in.low  = read_data;
                     state_in.step = ame_pkg::STEP_3;
                     res           = make_read(state_ff.ptr + 16'd1);
                  end
                  default: begin
                     state_in.busy = 1'b0;
                     res = make_done(base, state_ff.pc + 16'd2, 16'h0000, 1'b0);
                  end
               endcase
            end
            ame_pkg::MODE_REL: begin
               state_in.busy = 1'b0;
               res = make_done(16'h0000, state_ff.pc + 16'd1, rel16, 1'b0);
            end
            ame_pkg::MODE_ZP: begin
               state_in.busy = 1'b0;
               res = make_done({8'h00, read_data}, state_ff.pc + 16'd1, 16'h0000, 1'b0);
            end
            ame_pkg::MODE_ZPX: begin
               state_in.busy = 1'b0;
               res = make_done({8'h00, 8'(read_data + state_ff.x)}, state_ff.pc + 16'd1,
                               16'h0000, 1'b0);
            end
            ame_pkg::MODE_ZPY: begin
               state_in.busy = 1'b0;
               res = make_done({8'h00, 8'(read_data + state_ff.y)}, state_ff.pc + 16'd1,
                               16'h0000, 1'b0);
            end
            ame_pkg::MODE_IZX, ame_pkg::MODE_IZP, ame_pkg::MODE_IZY: begin
               case (state_ff.step)
                  ame_pkg::STEP_0: begin
                     state_in.ptr  = {8'h00, zp_ptr};
                     state_in.step = ame_pkg::STEP_1;
                     res           = make_read({8'h00, zp_ptr});
                  end
                  ame_pkg::STEP_1: begin
                     state_in.low  = read_data;
                     state_in.step = ame_pkg::STEP_2;
                     res           = make_read({8'h00, 8'(state_ff.ptr[7:0] + 8'd1)});
                  end
                  default: begin
                     state_in.busy = 1'b0;
                     res = make_done(ea, state_ff.pc + 16'd1, 16'h0000,
                                     base[15:8] != ea[15:8]);
                  end
               endcase
            end
            ame_pkg::MODE_ZPR: begin
               if (state_ff.step == ame_pkg::STEP_0) begin
                  state_in.low  = read_data;
                  state_in.step = ame_pkg::STEP_1;
                  res           = make_read(state_ff.pc + 16'd1);
               end else begin
                  state_in.busy = 1'b0;
                  res = make_done({8'h00, state_ff.low}, state_ff.pc + 16'd2, rel16, 1'b0);
               end
            end
            default: begin
               state_in.busy = 1'b0;
               has_res       = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   assign result.push = accept & has_res;
   assign result.data = res;

endmodule

`default_nettype wire

/* rtl/core/ame_outq.sv */
// ----------------------------------------------------------------------------
// ame_outq
// result register with skid stage between sequencer and response channel
// ----------------------------------------------------------------------------
`default_nettype none
`include "addressing_mode_effective_address_macros.svh"

module ame_outq (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ame_pkg::push_type   in_push,
   output logic                     full,
   output logic                     out_valid,
   input  wire logic                out_stall,
   output ame_pkg::result_type      out_data
);

   logic                head_valid_ff;
   logic                head_valid_in;
   logic                skid_valid_ff;
   logic                skid_valid_in;
   ame_pkg::result_type head_ff;
   ame_pkg::result_type head_in;
   ame_pkg::result_type skid_ff;
   ame_pkg::result_type skid_in;
   logic                pop;

   assign pop = head_valid_ff & ~out_stall;

   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else if (in_push.push) begin
            head_in = in_push.data;
         end else begin
            head_valid_in = 1'b0;
         end
      end else if (in_push.push) begin
         if (!head_valid_ff) begin
            head_in       = in_push.data;
            head_valid_in = 1'b1;
         end else begin
            skid_in       = in_push.data;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = head_valid_ff;
   assign out_data  = head_ff;

   `AME_ASSERT(a_skid_needs_head, clock, reset, skid_valid_ff |-> head_valid_ff, "skid without head")
   `AME_ASSERT(a_no_push_when_full, clock, reset, in_push.push |-> !skid_valid_ff, "push while full")
   `AME_ASSERT(a_skid_drains, clock, reset, (pop && skid_valid_ff) |=> (head_valid_ff && !skid_valid_ff), "skid not drained")
   `AME_ASSERT(a_empty_push_to_head, clock, reset, (!head_valid_ff && in_push.push) |=> (head_valid_ff && !skid_valid_ff), "push lost")

endmodule

`default_nettype wire

/* rtl/core/addressing_mode_effective_address.sv */
// ----------------------------------------------------------------------------
// addressing_mode_effective_address
// effective address sequencer for the sixteen 65c02 addressing modes
// ----------------------------------------------------------------------------
// usage
//   req channel: a start transfer (op 0) loads mode, pc, x and y; each data
//   transfer (op 1) returns the byte for the previous read request.
//   rsp channel: one result per transfer that produces one: a read request
//   (kind 0) or the final done result (kind 1) with effective address,
//   next pc, sign-extended branch offset and page-cross flag.
//   a data transfer while no calculation runs produces no result.
//   the step logic sits between the state registers and a result register
//   with one skid entry; each result is registered there. throughput: one
//   transfer per cycle while req_stall is low.
//   req_stall rises only when both the result register and the skid entry
//   are held by a stalled response channel; it drops as soon as rsp drains.
//   reset (synchronous, active high) clears the sequencer and empties the
//   result register; a start transfer may follow in the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module addressing_mode_effective_address (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_op,
   input  wire logic [3:0]  req_mode,
   input  wire logic [15:0] req_pc,
   input  wire logic [7:0]  req_x,
   input  wire logic [7:0]  req_y,
   input  wire logic [7:0]  req_read_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_kind,
   output logic [15:0]      rsp_read_address,
   output logic [15:0]      rsp_effective_address,
   output logic [15:0]      rsp_next_pc,
   output logic [15:0]      rsp_relative_offset,
   output logic             rsp_page_crossed
);

   logic                accept;
   logic                full;
   ame_pkg::push_type   push;
   ame_pkg::result_type rsp_data;

   assign req_stall = full;
   assign accept    = req_valid & ~full;

   ame_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .op        (req_op),
      .mode      (req_mode),
      .pc        (req_pc),
      .x         (req_x),
      .y         (req_y),
      .read_data (req_read_data),
      .result    (push)
   );

   ame_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .in_push   (push),
      .full      (full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign rsp_kind              = rsp_data.kind;
   assign rsp_read_address      = rsp_data.read_address;
   assign rsp_effective_address = rsp_data.effective_address;
   assign rsp_next_pc           = rsp_data.next_pc;
   assign rsp_relative_offset   = rsp_data.relative_offset;
   assign rsp_page_crossed      = rsp_data.page_crossed;

endmodule

`default_nettype wire
